@@ rtl/core/grid_lod_index_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid LOD index generator
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_LOD_INDEX_GENERATOR_ASSERT_SVH
`define GRID_LOD_INDEX_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// check a property at every rising clock edge outside reset
`define GLOD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check a non-overlapping implication outside reset
`define GLOD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define GLOD_ASSERT(lbl, clk, rstn, prop, msg)
`define GLOD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ rtl/core/glod_pkg.sv @@
// ----------------------------------------------------------------------------
// glod_pkg
// Shared types and constants of the grid LOD index generator.
// ----------------------------------------------------------------------------
package glod_pkg;

    localparam int unsigned MAX_SIZE_LOG2_DEF = 8;
    localparam int unsigned IDX_W             = 17;
    localparam int unsigned CFG_IDX_W         = 4;
    localparam int unsigned CFG_DATA_W        = 4;
    localparam int unsigned VTX_BORDER        = 3;
    localparam int unsigned QUAD_CORNERS      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_KIND    = 4'd0,
        CFG_DETAIL_LEVEL   = 4'd1,
        CFG_GRID_SIZE_LOG2 = 4'd2,
        CFG_STRIPE_LOG2    = 4'd3
    } t_cfg_reg;

    typedef enum logic {
        KIND_PATCH = 1'b0,
        KIND_SKIRT = 1'b1
    } t_buffer_kind;

    // effective (saturated) walk configuration
    typedef struct packed {
        t_buffer_kind kind;
        logic [3:0]   size_log2;
        logic [3:0]   lod;
        logic [3:0]   stripe_w_log2;
    } t_walk_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             last_of_buffer;
    } t_result;

endpackage

@@ rtl/core/glod_ifs.sv @@
// ----------------------------------------------------------------------------
// glod interfaces
// Valid/ready channels for restart input, index output and register writes.
// ----------------------------------------------------------------------------
interface glod_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface glod_out_if import glod_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;
    logic             last_of_buffer;

    modport source (output valid, output vertex_index, output last_of_buffer, input ready);
    modport sink   (input valid, input vertex_index, input last_of_buffer, output ready);
endinterface

interface glod_cfg_if import glod_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/glod_cfg.sv @@
// ----------------------------------------------------------------------------
// glod_cfg
// Configuration registers, saturation of the effective walk parameters.
// ----------------------------------------------------------------------------
module glod_cfg import glod_pkg::*; #(
    parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_walk_cfg             o_cfg,
    output logic                  o_restart
);

    t_buffer_kind r_kind;
    logic [3:0]   r_detail;
    logic [3:0]   r_size;
    logic [3:0]   r_stripe;
    logic         r_restart;

    logic [3:0] g_eff;
    logic [3:0] l_eff;
    logic [4:0] w_sum;

    assign o_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_PATCH;
            r_detail  <= 4'd0;
            r_size    <= 4'd6;
            r_stripe  <= 4'd3;
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_valid) begin
                case (i_index)
                    CFG_BUFFER_KIND: begin
                        r_kind    <= t_buffer_kind'(i_data[0]);
                        r_restart <= 1'b1;
                    end
                    CFG_DETAIL_LEVEL: begin
                        r_detail  <= i_data;
                        r_restart <= 1'b1;
                    end
                    CFG_GRID_SIZE_LOG2: begin
                        r_size    <= i_data;
                        r_restart <= 1'b1;
                    end
                    CFG_STRIPE_LOG2: begin
                        r_stripe  <= i_data;
                        r_restart <= 1'b1;
                    end
                    default: begin
                        r_restart <= 1'b0;
                    end
                endcase
            end
        end
    end

    // saturate size, then detail, then stripe width
    always_comb begin
        g_eff = (r_size > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2) : r_size;
        l_eff = (r_detail > g_eff) ? g_eff : r_detail;
        w_sum = {1'b0, r_stripe} + {1'b0, l_eff};
        o_cfg.kind          = r_kind;
        o_cfg.size_log2     = g_eff;
        o_cfg.lod           = l_eff;
        o_cfg.stripe_w_log2 = (w_sum > {1'b0, g_eff}) ? g_eff : w_sum[3:0];
    end

    assign o_restart = r_restart;

endmodule

@@ rtl/core/glod_walk.sv @@
// ----------------------------------------------------------------------------
// glod_walk
// Walk state, quad corner selection and vertex index arithmetic.
// ----------------------------------------------------------------------------
`include "grid_lod_index_generator_assert.svh"

module glod_walk import glod_pkg::*; #(
    parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_walk_cfg i_cfg,
    input  logic      i_cfg_restart,
    input  logic      i_accept,
    input  logic      i_restart,
    output t_result   o_res
);

    localparam int unsigned POS_W  = MAX_SIZE_LOG2 + 2;
    localparam int unsigned CNT_W  = MAX_SIZE_LOG2 + 1;
    localparam int unsigned PROD_W = (2 * MAX_SIZE_LOG2 + 4 > IDX_W) ?
                                     (2 * MAX_SIZE_LOG2 + 4) : IDX_W;

    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [2:0]       r_corner;

    logic [CNT_W-1:0] n_cnt;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] n_col;
    logic [2:0]       n_corner;

    logic             do_start;
    logic [POS_W-1:0] start_row;
    logic [CNT_W-1:0] cur_cnt;
    logic [POS_W-1:0] cur_row;
    logic [POS_W-1:0] cur_col;
    logic [2:0]       cur_corner;
    logic [2:0]       k;

    logic [POS_W-1:0] s_len;
    logic [POS_W-1:0] s_p1;
    logic [POS_W-1:0] d_step;
    logic [POS_W-1:0] dr;
    logic [POS_W-1:0] dc;
    logic [CNT_W-1:0] n_stripes;
    logic [CNT_W-1:0] cnt_p1;
    logic [CNT_W-1:0] cnt_wrap;
    logic [POS_W-1:0] stripe_end;
    logic [POS_W-1:0] stripe_base;
    logic [POS_W-1:0] row_d;
    logic [POS_W-1:0] col_d;
    logic             horiz;
    logic             last_quad;
    logic [POS_W-1:0] vr;
    logic [POS_W-1:0] vc;
    logic [PROD_W-1:0] prod;

    function automatic logic row_used(input logic [2:0] c);
        case (c)
            3'd1, 3'd2, 3'd3: row_used = 1'b1;
            default:          row_used = 1'b0;
        endcase
    endfunction

    function automatic logic col_used(input logic [2:0] c);
        case (c)
            3'd2, 3'd3, 3'd4: col_used = 1'b1;
            default:          col_used = 1'b0;
        endcase
    endfunction

    always_comb begin
        s_len     = POS_W'(1) << i_cfg.size_log2;
        s_p1      = s_len + POS_W'(1);
        d_step    = POS_W'(1) << i_cfg.lod;
        n_stripes = CNT_W'(s_len >> i_cfg.stripe_w_log2);

        // restart from a register write or from the item itself
        do_start  = i_cfg_restart || (i_accept && i_restart);
        start_row = (i_cfg.kind == KIND_SKIRT) ? POS_W'(0) : POS_W'(1);
        cur_cnt    = do_start ? CNT_W'(0) : r_cnt;
        cur_row    = do_start ? start_row : r_row;
        cur_col    = do_start ? POS_W'(1) : r_col;
        cur_corner = do_start ? 3'd0      : r_corner;
        k = (cur_corner < 3'(QUAD_CORNERS)) ? cur_corner : 3'd0;

        horiz = (cur_cnt < CNT_W'(2));
        if (i_cfg.kind == KIND_SKIRT) begin
            dr = horiz ? POS_W'(1) : d_step;
            dc = horiz ? d_step : POS_W'(1);
        end else begin
            dr = d_step;
            dc = d_step;
        end

        cnt_p1      = cur_cnt + CNT_W'(1);
        stripe_end  = (POS_W'(cnt_p1) << i_cfg.stripe_w_log2) + POS_W'(1);
        stripe_base = (POS_W'(cur_cnt) << i_cfg.stripe_w_log2) + POS_W'(1);
        row_d       = cur_row + d_step;
        col_d       = cur_col + d_step;

        if (i_cfg.kind == KIND_SKIRT) begin
            last_quad = (cur_cnt >= CNT_W'(3)) && (row_d >= s_p1);
        end else begin
            last_quad = (cnt_p1 >= n_stripes) && (row_d >= s_p1) && (col_d >= stripe_end);
        end

        // index = r * (size + 3) + c
        vr   = cur_row + (row_used(k) ? dr : POS_W'(0));
        vc   = cur_col + (col_used(k) ? dc : POS_W'(0));
        prod = (PROD_W'(vr) << i_cfg.size_log2) + PROD_W'(vr) * PROD_W'(VTX_BORDER)
             + PROD_W'(vc);
        o_res.vertex_index   = prod[IDX_W-1:0];
        o_res.last_of_buffer = last_quad && (k == 3'(QUAD_CORNERS - 1));
    end

    // next walk position
    always_comb begin
        n_cnt    = cur_cnt;
        n_row    = cur_row;
        n_col    = cur_col;
        n_corner = 3'd0;
        cnt_wrap = cnt_p1;
        if (!i_accept) begin
            // register write without an item: hold the start position
            n_corner = cur_corner;
        end else if (k < 3'(QUAD_CORNERS - 1)) begin
            n_corner = k + 3'd1;
        end else if (last_quad) begin
            n_cnt = CNT_W'(0);
            n_row = start_row;
            n_col = POS_W'(1);
        end else if (i_cfg.kind == KIND_SKIRT) begin
            if (horiz) begin
                n_col = col_d;
            end else begin
                n_row = row_d;
            end
            if ((horiz && col_d >= s_p1) || (!horiz && row_d >= s_p1)) begin
                cnt_wrap = (cnt_p1 >= CNT_W'(4)) ? CNT_W'(0) : cnt_p1;
                n_cnt    = cnt_wrap;
                case (cnt_wrap[1:0])
                    2'd0: begin
                        n_row = POS_W'(0);
                        n_col = POS_W'(1);
                    end
                    2'd1: begin
                        n_row = s_p1;
                        n_col = POS_W'(1);
                    end
                    2'd2: begin
                        n_row = POS_W'(1);
                        n_col = POS_W'(0);
                    end
                    default: begin
                        n_row = POS_W'(1);
                        n_col = s_p1;
                    end
                endcase
            end
        end else begin
            n_col = col_d;
            if (col_d >= stripe_end) begin
                n_col = stripe_base;
                n_row = row_d;
                if (row_d >= s_p1) begin
                    n_row    = POS_W'(1);
                    cnt_wrap = (cnt_p1 >= n_stripes) ? CNT_W'(0) : cnt_p1;
                    n_cnt    = cnt_wrap;
                    n_col    = (POS_W'(cnt_wrap) << i_cfg.stripe_w_log2) + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_row    <= POS_W'(1);
            r_col    <= POS_W'(1);
            r_corner <= 3'd0;
        end else if (i_accept || i_cfg_restart) begin
            r_cnt    <= n_cnt;
            r_row    <= n_row;
            r_col    <= n_col;
            r_corner <= n_corner;
        end
    end

    `GLOD_ASSERT(a_corner_range, i_clk, i_rst_n, r_corner < 3'(QUAD_CORNERS), "corner step out of range")
    `GLOD_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, i_cfg_restart && !i_accept, r_corner == 3'd0 && r_cnt == '0 && r_col == POS_W'(1), "register write did not restart the walk")
    `GLOD_ASSERT_NEXT(a_wrap_after_last, i_clk, i_rst_n, i_accept && o_res.last_of_buffer, r_corner == 3'd0 && r_cnt == '0, "walk did not wrap after last index")

endmodule

@@ rtl/core/glod_out.sv @@
// ----------------------------------------------------------------------------
// glod_out
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
`include "grid_lod_index_generator_assert.svh"

module glod_out import glod_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take    = r_main_v && i_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (i_push && !r_main_v) begin
            r_main <= i_res;
        end
        if (i_push && r_main_v && !take) begin
            r_skid <= i_res;
        end
    end

    `GLOD_ASSERT(a_skid_implies_main, i_clk, i_rst_n, !r_skid_v || r_main_v, "skid entry without result entry")
    `GLOD_ASSERT_NEXT(a_main_held, i_clk, i_rst_n, r_main_v && !take, r_main_v, "pending result dropped")
    `GLOD_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, i_push && r_main_v && !take, r_skid_v, "stalled transfer not captured")

endmodule

@@ rtl/core/grid_lod_index_generator.sv @@
// ----------------------------------------------------------------------------
// grid_lod_index_generator
// A result is registered into the output buffer on its input transfer.
// Throughput: one index per cycle unless the skid entry is full, set by the
// walk update and the two-entry output buffer that keeps input open.
// Reset (synchronous, active low): registers to defaults, walk at patch start.
// ----------------------------------------------------------------------------
module grid_lod_index_generator import glod_pkg::*; #(
    parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    glod_in_if.sink         i_in,
    glod_out_if.source      o_out,
    glod_cfg_if.sink        i_cfg
);

    t_walk_cfg walk_cfg;
    logic      cfg_restart;
    logic      in_accept;
    t_result   walk_res;
    t_result   out_res;

    // Register bank: a write to a listed register also flags a walk restart,
    // which the walker applies on the following cycle with the new settings.
    glod_cfg #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cfg.valid),
        .o_ready   (i_cfg.ready),
        .i_index   (i_cfg.index),
        .i_data    (i_cfg.data),
        .o_cfg     (walk_cfg),
        .o_restart (cfg_restart)
    );

    // An input transfer computes the current index from the walk state and
    // advances the state in the same cycle.
    assign in_accept = i_in.valid && i_in.ready;

    glod_walk #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (walk_cfg),
        .i_cfg_restart (cfg_restart),
        .i_accept      (in_accept),
        .i_restart     (i_in.restart),
        .o_res         (walk_res)
    );

    // Output buffer: hold the result until its transfer; the skid entry
    // absorbs one more index so input stays open during an output stall.
    glod_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_res   (walk_res),
        .o_ready (i_in.ready),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.vertex_index   = out_res.vertex_index;
    assign o_out.last_of_buffer = out_res.last_of_buffer;

endmodule

@@ tb/glod_index_checker.sv @@
// ----------------------------------------------------------------------------
// glod_index_checker
// Watches the restart, index and register channels of the grid LOD index
// generator, walks its own copy of the grid and compares every index.
// ----------------------------------------------------------------------------
module glod_index_checker import glod_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    glod_in_if   i_restart,
    glod_out_if  i_index,
    glod_cfg_if  i_reg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [3:0] LOD_RESET    = 4'd0;
    localparam logic [3:0] SIZE_RESET   = 4'd6;
    localparam logic [3:0] STRIPE_RESET = 4'd3;

    // register copies
    t_buffer_kind cfg_kind;
    logic [3:0]   cfg_lod;
    logic [3:0]   cfg_size;
    logic [3:0]   cfg_stripe;

    // walk position
    logic [8:0]   band;
    logic [9:0]   row_pos;
    logic [9:0]   col_pos;
    logic [2:0]   corner;

    t_result      expected_indices[$];

    function automatic int unsigned eff_size_log2();
        return (cfg_size > MAX_SIZE_LOG2_DEF) ? MAX_SIZE_LOG2_DEF : int'(cfg_size);
    endfunction

    function automatic int unsigned eff_lod();
        int unsigned g;
        g = eff_size_log2();
        return (cfg_lod > g) ? g : int'(cfg_lod);
    endfunction

    function automatic int unsigned eff_stripe_log2();
        int unsigned g;
        int unsigned w;
        g = eff_size_log2();
        w = cfg_stripe + eff_lod();
        return (w > g) ? g : w;
    endfunction

    // border edges: top, bottom, left, right
    function automatic void place_on_edge(input int unsigned e, input int unsigned s);
        case (e)
            0: begin
                row_pos = 10'd0;
                col_pos = 10'd1;
            end
            1: begin
                row_pos = 10'(s + 1);
                col_pos = 10'd1;
            end
            2: begin
                row_pos = 10'd1;
                col_pos = 10'd0;
            end
            default: begin
                row_pos = 10'd1;
                col_pos = 10'(s + 1);
            end
        endcase
    endfunction

    function automatic void restart_walk();
        band   = '0;
        corner = '0;
        if (cfg_kind == KIND_SKIRT) begin
            place_on_edge(0, 1 << eff_size_log2());
        end else begin
            row_pos = 10'd1;
            col_pos = 10'd1;
        end
    endfunction

    // unknown indexes leave the walk alone
    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_BUFFER_KIND:    cfg_kind   = t_buffer_kind'(val[0]);
            CFG_DETAIL_LEVEL:   cfg_lod    = val;
            CFG_GRID_SIZE_LOG2: cfg_size   = val;
            CFG_STRIPE_LOG2:    cfg_stripe = val;
            default:            return;
        endcase
        restart_walk();
    endfunction

    // produce the index of one advance and step the walk
    function automatic t_result next_index(input logic restart);
        t_result     res;
        int unsigned s;
        int unsigned d;
        int unsigned w;
        int unsigned stripes;
        int unsigned dr;
        int unsigned dc;
        int unsigned r;
        int unsigned c;
        int unsigned k;
        bit          last_quad;

        if (restart) restart_walk();

        s       = 1 << eff_size_log2();
        d       = 1 << eff_lod();
        w       = 1 << eff_stripe_log2();
        stripes = s / w;

        if (cfg_kind == KIND_SKIRT) begin
            dr        = (band < 2) ? 1 : d;
            dc        = (band < 2) ? d : 1;
            last_quad = (band >= 3) && (row_pos + d >= s + 1);
        end else begin
            dr        = d;
            dc        = d;
            last_quad = (band + 1 >= stripes) && (row_pos + d >= s + 1)
                        && (col_pos + d >= (band + 1) * w + 1);
        end

        k = (corner < 6) ? corner : 0;
        r = row_pos + ((k >= 1 && k <= 3) ? dr : 0);
        c = col_pos + ((k >= 2 && k <= 4) ? dc : 0);
        res.vertex_index   = IDX_W'(r * (s + 3) + c);
        res.last_of_buffer = last_quad && (k == 5);

        if (k < 5) begin
            corner = 3'(k + 1);
            return res;
        end
        corner = '0;
        if (last_quad) begin
            restart_walk();
            return res;
        end

        if (cfg_kind == KIND_SKIRT) begin
            if (band < 2) begin
                col_pos = 10'(col_pos + d);
                if (col_pos >= s + 1) begin
                    band = band + 1;
                    place_on_edge(band, s);
                end
            end else begin
                row_pos = 10'(row_pos + d);
                if (row_pos >= s + 1) begin
                    band = band + 1;
                    if (band >= 4) band = '0;
                    place_on_edge(band, s);
                end
            end
        end else begin
            col_pos = 10'(col_pos + d);
            if (col_pos >= (band + 1) * w + 1) begin
                col_pos = 10'(band * w + 1);
                row_pos = 10'(row_pos + d);
                if (row_pos >= s + 1) begin
                    row_pos = 10'd1;
                    band    = band + 1;
                    if (band >= stripes) band = '0;
                    col_pos = 10'(band * w + 1);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_kind   = KIND_PATCH;
            cfg_lod    = LOD_RESET;
            cfg_size   = SIZE_RESET;
            cfg_stripe = STRIPE_RESET;
            restart_walk();
            expected_indices.delete();
        end else begin
            // compare results first: they belong to earlier transfers
            if (i_index.valid && i_index.ready) begin
                got.vertex_index   = i_index.vertex_index;
                got.last_of_buffer = i_index.last_of_buffer;
                if (expected_indices.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected index %0d (last %0b), none expected",
                             $time, got.vertex_index, got.last_of_buffer);
                end else begin
                    want = expected_indices.pop_front();
                    if (got.vertex_index !== want.vertex_index) begin
                        o_fail_count++;
                        $display("%0t: vertex_index expected %0d, got %0d",
                                 $time, want.vertex_index, got.vertex_index);
                    end
                    if (got.last_of_buffer !== want.last_of_buffer) begin
                        o_fail_count++;
                        $display("%0t: last_of_buffer expected %0b, got %0b",
                                 $time, want.last_of_buffer, got.last_of_buffer);
                    end
                end
            end
            if (i_reg.valid && i_reg.ready) load_register(i_reg.index, i_reg.data);
            if (i_restart.valid && i_restart.ready)
                expected_indices.push_back(next_index(i_restart.restart));
        end
        o_pending = expected_indices.size();
    end

endmodule

@@ tb/grid_lod_index_generator_tb.sv @@
// ----------------------------------------------------------------------------
// grid_lod_index_generator_tb
// Drives advance/restart transfers and register writes into the grid LOD
// index generator with random gaps and back-pressure; a checker beside the
// block predicts every index and end-of-buffer flag and counts mismatches.
// ----------------------------------------------------------------------------
module grid_lod_index_generator_tb;
    import glod_pkg::*;

    localparam int unsigned           RANDOM_ITEMS  = 1200;
    localparam int unsigned           HOLD_OFF_LEN  = 60;
    // a register slot the block does not decode
    localparam logic [CFG_IDX_W-1:0]  SPARE_REG     = 4'd13;
    localparam logic [CFG_IDX_W-1:0]  FIRST_UNUSED  = 4'd4;
    localparam logic [CFG_IDX_W-1:0]  LAST_UNUSED   = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;

    glod_in_if  restart_ch();
    glod_out_if index_ch();
    glod_cfg_if reg_ch();

    int  fail_count;
    int  pending;

    // transfer counters, updated after each edge
    int  n_sent     = 0;
    int  n_restarts = 0;
    int  n_results  = 0;
    int  n_wraps    = 0;
    int  n_writes   = 0;

    // pacing knobs set by the sender; the receiver tracks hold-off
    // requests with a count of its own
    bit          quiet        = 1'b0;
    int unsigned hold_off_req = 0;

    always #1 i_clk = ~i_clk;

    grid_lod_index_generator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (restart_ch),
        .o_out   (index_ch),
        .i_cfg   (reg_ch)
    );

    glod_index_checker index_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart_ch),
        .i_index      (index_ch),
        .i_reg        (reg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Count transfers on both sides of the block.
    always @(posedge i_clk) begin
        if (i_rst_n && restart_ch.valid && restart_ch.ready) begin
            n_sent <= n_sent + 1;
            if (restart_ch.restart) n_restarts <= n_restarts + 1;
        end
        if (i_rst_n && index_ch.valid && index_ch.ready) begin
            n_results <= n_results + 1;
            if (index_ch.last_of_buffer) n_wraps <= n_wraps + 1;
        end
    end

    // Offer one advance (or restart) after a random gap, then hold it until
    // the transfer. Valid stays high across back-to-back items, so it is
    // only dropped when a gap follows.
    task automatic send_item(input logic walk_restart);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            restart_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        restart_ch.valid   <= 1'b1;
        restart_ch.restart <= walk_restart;
        do @(posedge i_clk); while (!restart_ch.ready);
    endtask

    // Hold a register write until the transfer. Valid is left high so that
    // a following write needs no drop; the caller drops it at the end.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        n_writes++;
    endtask

    // Wait until every index offered so far has come back.
    task automatic settle();
        @(posedge i_clk);
        while (n_results != n_sent) @(posedge i_clk);
    endtask

    // Receiver: stall a random number of cycles before each index, or for a
    // long stretch when the stimulus asks for a hold-off, so that the output
    // buffer fills and the block stops taking advances.
    initial begin : receiver
        int unsigned stall;
        int unsigned hold_off_done;
        hold_off_done  = 0;
        index_ch.ready <= 1'b0;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (hold_off_req != hold_off_done) begin
                stall         = HOLD_OFF_LEN;
                hold_off_done = hold_off_req;
            end
            if (stall != 0) begin
                index_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            index_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(index_ch.valid && index_ch.ready));
        end
    end

    initial begin : stimulus
        int unsigned              n_random;
        int unsigned              phase;
        int unsigned              batch;
        int unsigned              pick;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;

        // drive every input to a known value before the first edge
        i_rst_n            <= 1'b0;
        restart_ch.valid   <= 1'b0;
        restart_ch.restart <= 1'b0;
        reg_ch.valid       <= 1'b0;
        reg_ch.index       <= CFG_BUFFER_KIND;
        reg_ch.data        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: restart, then advance a couple of indices.
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        restart_ch.valid <= 1'b0;
        settle();

        // Single-quad patch at the finest detail and narrowest stripe: the
        // buffer is one quad, so the sixth index shows the wrap.
        write_reg(CFG_DETAIL_LEVEL, 4'd0);
        write_reg(CFG_STRIPE_LOG2, 4'd0);
        write_reg(CFG_GRID_SIZE_LOG2, 4'd0);
        reg_ch.valid <= 1'b0;
        repeat (7) send_item(1'b0);
        restart_ch.valid <= 1'b0;
        settle();

        // Skirt with every field at its top: the grid saturates to the
        // largest size, detail to one quad per side, the stripe to the grid.
        // Kind is written with its upper data bits set, which must be dropped.
        write_reg(CFG_BUFFER_KIND, 4'hF);
        write_reg(CFG_GRID_SIZE_LOG2, 4'hF);
        write_reg(CFG_DETAIL_LEVEL, 4'hF);
        write_reg(CFG_STRIPE_LOG2, 4'hF);
        reg_ch.valid <= 1'b0;
        repeat (7) send_item(1'b0);
        restart_ch.valid <= 1'b0;
        settle();

        // A write to an undecoded slot must leave the walk mid-quad.
        write_reg(SPARE_REG, 4'hA);
        reg_ch.valid <= 1'b0;
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        restart_ch.valid <= 1'b0;
        settle();

        // Random phases: rewrite a few registers, then run a batch of mostly
        // plain advances with the odd restart. Small grids dominate so that
        // whole buffers, and their wraps, fit in a batch.
        n_random = 0;
        phase    = 0;
        while (n_random < RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 19);
                if (pick >= 16) begin
                    reg_idx = CFG_IDX_W'($urandom_range(LAST_UNUSED, FIRST_UNUSED));
                    reg_val = CFG_DATA_W'($urandom_range(0, 15));
                end else begin
                    reg_idx = t_cfg_reg'($urandom_range(int'(CFG_STRIPE_LOG2),
                                                        int'(CFG_BUFFER_KIND)));
                    if (reg_idx == CFG_GRID_SIZE_LOG2 && $urandom_range(0, 3) != 0)
                        reg_val = CFG_DATA_W'($urandom_range(0, 3));
                    else
                        reg_val = CFG_DATA_W'($urandom_range(0, 15));
                end
                write_reg(reg_idx, reg_val);
            end
            reg_ch.valid <= 1'b0;

            // one phase runs the long receiver hold-off, some run flat out
            if (phase == 2) begin
                quiet = 1'b1;
                hold_off_req++;
                batch = 150;
            end else begin
                quiet = ($urandom_range(0, 4) == 0);
                batch = $urandom_range(20, 100);
            end

            repeat (batch) begin
                send_item($urandom_range(0, 49) == 0);
                n_random++;
            end
            restart_ch.valid <= 1'b0;
            settle();
            quiet = 1'b0;
            phase++;
        end

        // let any late index show up before the verdict
        repeat (4) @(posedge i_clk);

        $display("covered %0d advance transfers (%0d restarts) over %0d register writes",
                 n_sent, n_restarts, n_writes);
        $display("checked %0d indices, %0d of them flagged as end of buffer",
                 n_results, n_wraps);
        if (fail_count == 0 && pending == 0) begin
            $display("grid_lod_index_generator_tb passed");
        end else begin
            $display("grid_lod_index_generator_tb failed");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #2000000;
        $display("grid_lod_index_generator_tb failed");
        $finish;
    end

endmodule
